/* sv/grid_gradient_field_macros.svh */
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef GRID_GRADIENT_FIELD_MACROS_SVH
`define GRID_GRADIENT_FIELD_MACROS_SVH

`define GGF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error("ggf check failed");

`define GGF_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error("ggf check failed");

`endif

/* sv/ggf_pkg.sv */
package ggf_pkg;

	localparam int SAMP_W     = 16;
	localparam int DIFF_W     = 17;
	localparam int INV_W      = 24;
	localparam int PROD_W     = DIFF_W + INV_W;
	localparam int MAG_W      = 25;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int REM_W      = MAG_W + 2;
	localparam int FIELD_W    = 27;
	localparam int OUTMAG_W   = 26;
	localparam int IDX_W      = 10;
	localparam int CNT_W      = 11;
	localparam int CNT_MAX    = 2047;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int STEP_W     = 5;
	localparam int RD_STEPS   = 4;
	localparam int SQRT_STEPS = MAG_W;

	localparam logic [CNT_W-1:0] CNT_RST = 11'd1024;
	localparam logic [INV_W-1:0] INV_RST = 24'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT = 2'd0,
		REG_COL_COUNT = 2'd1,
		REG_INV_ROW   = 2'd2,
		REG_INV_COL   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic       wr_en;
		logic [1:0] wr_slot;
		logic       rd_en;
		logic [1:0] rd_slot;
		logic [1:0] rd_idx;
		logic       diff_en;
		logic       mul_en;
		logic       sq_en;
		logic       sum_en;
		logic       sqrt_en;
		logic       load_en;
		logic       row_central;
		logic       col_central;
		logic       last;
	} ggf_cmd_t;

	// slot of the row k rows above the row held in slot s, modulo 3
	function automatic logic [1:0] slot_back(logic [1:0] s, logic [1:0] k);
		logic [2:0] t;
		t = {1'b0, s} + 3'd3 - {1'b0, k};
		if (t >= 3'd3) begin
			t = t - 3'd3;
		end
		return t[1:0];
	endfunction

endpackage

/* sv/ggf_if.sv */
interface ggf_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] potential;

	modport source(output valid, output potential, input ready);
	modport sink(input valid, input potential, output ready);
endinterface

interface ggf_out_if;
	logic               valid;
	logic               ready;
	logic        [9:0]  out_row;
	logic        [9:0]  out_col;
	logic signed [26:0] field_row_dir;
	logic signed [26:0] field_col_dir;
	logic        [25:0] magnitude;
	logic               last_of_grid;

	modport source(output valid, output out_row, output out_col, output field_row_dir,
		output field_col_dir, output magnitude, output last_of_grid, input ready);
	modport sink(input valid, input out_row, input out_col, input field_row_dir,
		input field_col_dir, input magnitude, input last_of_grid, output ready);
endinterface

/* sv/ggf_datapath.sv */
module ggf_datapath #(
	parameter int CMAX = 1024,
	parameter int CIW  = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [ggf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ggf_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  ggf_pkg::ggf_cmd_t                   cmd,
	input  logic [CIW-1:0]                      wr_col,
	input  logic [CIW-1:0]                      rd_col,
	input  logic signed [ggf_pkg::SAMP_W-1:0]   potential,
	input  logic [ggf_pkg::IDX_W-1:0]           pt_row,
	input  logic [ggf_pkg::IDX_W-1:0]           pt_col,
	output logic [ggf_pkg::IDX_W-1:0]           out_row,
	output logic [ggf_pkg::IDX_W-1:0]           out_col,
	output logic signed [ggf_pkg::FIELD_W-1:0]  field_row_dir,
	output logic signed [ggf_pkg::FIELD_W-1:0]  field_col_dir,
	output logic [ggf_pkg::OUTMAG_W-1:0]        magnitude,
	output logic                                last_of_grid
);
	import ggf_pkg::*;

	logic signed [SAMP_W-1:0] mem_q [3][CMAX];
	logic signed [SAMP_W-1:0] rdata_q;
	logic                     rdv_q;
	logic [1:0]               ridx_q;
	logic signed [SAMP_W-1:0] samp_q [RD_STEPS];
	logic [INV_W-1:0]         inv_row_q, inv_col_q;
	logic [DIFF_W-1:0]        absr_q, absc_q;
	logic                     posr_q, posc_q;
	logic [MAG_W-1:0]         mr_q, mc_q;
	logic [SQ_W-1:0]          sqr_q, sqc_q, rad_q;
	logic [REM_W-1:0]         rem_q;
	logic [MAG_W-1:0]         root_q;

	logic signed [DIFF_W-1:0] dr, dc;
	logic [PROD_W-1:0]        pr, pc;
	logic [REM_W+1:0]         remx, trial;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[cmd.wr_slot][wr_col] <= potential;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[cmd.rd_slot][rd_col];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_q     <= 1'b0;
			ridx_q    <= '0;
			inv_row_q <= INV_RST;
			inv_col_q <= INV_RST;
		end else begin
			rdv_q  <= cmd.rd_en;
			ridx_q <= cmd.rd_idx;
			if (cfg_wr_en) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_INV_ROW: inv_row_q <= cfg_data;
					REG_INV_COL: inv_col_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		dr    = {samp_q[0][SAMP_W-1], samp_q[0]} - {samp_q[1][SAMP_W-1], samp_q[1]};
		dc    = {samp_q[2][SAMP_W-1], samp_q[2]} - {samp_q[3][SAMP_W-1], samp_q[3]};
		pr    = PROD_W'(absr_q) * PROD_W'(inv_row_q);
		pc    = PROD_W'(absc_q) * PROD_W'(inv_col_q);
		remx  = {rem_q, rad_q[SQ_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
	end

	always_ff @(posedge clk) begin
		if (rdv_q) begin
			samp_q[ridx_q] <= rdata_q;
		end
		if (cmd.diff_en) begin
			absr_q <= dr[DIFF_W-1] ? DIFF_W'(-dr) : DIFF_W'(dr);
			absc_q <= dc[DIFF_W-1] ? DIFF_W'(-dc) : DIFF_W'(dc);
			posr_q <= !dr[DIFF_W-1] && (dr != '0);
			posc_q <= !dc[DIFF_W-1] && (dc != '0);
		end
		if (cmd.mul_en) begin
			mr_q <= cmd.row_central ? MAG_W'(pr >> 17) : MAG_W'(pr >> 16);
			mc_q <= cmd.col_central ? MAG_W'(pc >> 17) : MAG_W'(pc >> 16);
		end
		if (cmd.sq_en) begin
			sqr_q <= SQ_W'(mr_q) * SQ_W'(mr_q);
			sqc_q <= SQ_W'(mc_q) * SQ_W'(mc_q);
		end
		if (cmd.sum_en) begin
			rad_q  <= sqr_q + sqc_q;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_en) begin
			rad_q <= rad_q << 2;
			if (remx >= trial) begin
				rem_q  <= REM_W'(remx - trial);
				root_q <= {root_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q  <= remx[REM_W-1:0];
				root_q <= {root_q[MAG_W-2:0], 1'b0};
			end
		end
		if (cmd.load_en) begin
			out_row       <= pt_row;
			out_col       <= pt_col;
			field_row_dir <= posr_q ? FIELD_W'(27'd0 - {2'b00, mr_q}) : {2'b00, mr_q};
			field_col_dir <= posc_q ? FIELD_W'(27'd0 - {2'b00, mc_q}) : {2'b00, mc_q};
			magnitude     <= {1'b0, root_q};
			last_of_grid  <= cmd.last;
		end
	end

endmodule

/* sv/ggf_ctrl.sv */
`include "grid_gradient_field_macros.svh"

module ggf_ctrl #(
	parameter int RMAX = 1024,
	parameter int CIW  = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ggf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ggf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [ggf_pkg::CNT_W-1:0]      col_lim,
	input  logic                           in_valid,
	output logic                           in_ready,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ggf_pkg::ggf_cmd_t              cmd,
	output logic [CIW-1:0]                 wr_col,
	output logic [CIW-1:0]                 rd_col,
	output logic [ggf_pkg::IDX_W-1:0]      pt_row,
	output logic [ggf_pkg::IDX_W-1:0]      pt_col
);
	import ggf_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_RD   = 9'b000000010,
		S_WAIT = 9'b000000100,
		S_DIFF = 9'b000001000,
		S_MUL  = 9'b000010000,
		S_SQ   = 9'b000100000,
		S_SUM  = 9'b001000000,
		S_SQRT = 9'b010000000,
		S_LOAD = 9'b100000000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] rowc_q, colc_q;
	logic [CNT_W-1:0] row_pos_q, col_pos_q, ir_q, ic_q;
	logic [1:0]       slot_q, islot_q;
	logic [2:0]       pend_q;
	logic [STEP_W-1:0] cnt_q;
	logic             out_valid_q;

	logic [CNT_W-1:0] rows, cols, pi, pj, cn, cp, rcol;
	logic             accept, last_row, last_col, j0, jl;
	logic [2:0]       pend_new, psel, pend_left;
	logic [1:0]       oi_slot;

	always_comb begin
		rows = (rowc_q < 11'd3) ? 11'd3 : ((rowc_q > CNT_W'(RMAX)) ? CNT_W'(RMAX) : rowc_q);
		cols = (colc_q < 11'd3) ? 11'd3 : ((colc_q > col_lim) ? col_lim : colc_q);
		in_ready = (state_q == S_IDLE);
		accept   = in_valid && in_ready;
		last_row = (row_pos_q == rows - 11'd1);
		last_col = (col_pos_q == cols - 11'd1);
		pend_new = {last_row && last_col, last_row && (col_pos_q != '0), row_pos_q != '0};

		psel      = pend_q & (~pend_q + 3'd1);
		pend_left = pend_q & ~psel;
		pi = psel[0] ? ir_q - 11'd1 : ir_q;
		pj = psel[1] ? ic_q - 11'd1 : ic_q;
		j0 = (pj == '0);
		jl = (pj >= cols - 11'd1);
		cn = j0 ? 11'd1 : (jl ? cols - 11'd1 : pj + 11'd1);
		cp = j0 ? 11'd0 : (jl ? cols - 11'd2 : pj - 11'd1);
		oi_slot = slot_back(islot_q, psel[0] ? 2'd1 : 2'd0);

		cmd             = '0;
		cmd.row_central = psel[0] && (ir_q != 11'd1);
		cmd.col_central = !j0 && !jl;
		cmd.last        = psel[2];
		cmd.wr_en       = accept;
		cmd.wr_slot     = slot_q;
		cmd.rd_en       = (state_q == S_RD);
		cmd.rd_idx      = cnt_q[1:0];
		unique case (cnt_q[1:0])
			2'd0: begin
				cmd.rd_slot = islot_q;
				rcol        = pj;
			end
			2'd1: begin
				cmd.rd_slot = slot_back(islot_q, cmd.row_central ? 2'd2 : 2'd1);
				rcol        = pj;
			end
			2'd2: begin
				cmd.rd_slot = oi_slot;
				rcol        = cn;
			end
			default: begin
				cmd.rd_slot = oi_slot;
				rcol        = cp;
			end
		endcase
		cmd.diff_en = (state_q == S_DIFF);
		cmd.mul_en  = (state_q == S_MUL);
		cmd.sq_en   = (state_q == S_SQ);
		cmd.sum_en  = (state_q == S_SUM);
		cmd.sqrt_en = (state_q == S_SQRT);
		cmd.load_en = (state_q == S_LOAD) && (!out_valid_q || out_ready);
	end

	assign wr_col    = col_pos_q[CIW-1:0];
	assign rd_col    = rcol[CIW-1:0];
	assign pt_row    = pi[IDX_W-1:0];
	assign pt_col    = pj[IDX_W-1:0];
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rowc_q      <= CNT_RST;
			colc_q      <= CNT_RST;
			row_pos_q   <= '0;
			col_pos_q   <= '0;
			slot_q      <= '0;
			ir_q        <= '0;
			ic_q        <= '0;
			islot_q     <= '0;
			pend_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (accept) begin
				ir_q    <= row_pos_q;
				ic_q    <= col_pos_q;
				islot_q <= slot_q;
				pend_q  <= pend_new;
				if (last_col) begin
					col_pos_q <= '0;
					if (last_row) begin
						row_pos_q <= '0;
						slot_q    <= '0;
					end else begin
						row_pos_q <= row_pos_q + 11'd1;
						slot_q    <= (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
					end
				end else begin
					col_pos_q <= col_pos_q + 11'd1;
				end
			end

			if (cfg_wr_en) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_ROW_COUNT: begin
						rowc_q    <= cfg_data[CNT_W-1:0];
						row_pos_q <= '0;
						col_pos_q <= '0;
						slot_q    <= '0;
					end
					REG_COL_COUNT: begin
						colc_q    <= cfg_data[CNT_W-1:0];
						row_pos_q <= '0;
						col_pos_q <= '0;
						slot_q    <= '0;
					end
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept && (pend_new != '0)) begin
						state_q <= S_RD;
						cnt_q   <= '0;
					end
				end
				S_RD: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == STEP_W'(RD_STEPS - 1)) begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: state_q <= S_DIFF;
				S_DIFF: state_q <= S_MUL;
				S_MUL:  state_q <= S_SQ;
				S_SQ:   state_q <= S_SUM;
				S_SUM: begin
					state_q <= S_SQRT;
					cnt_q   <= '0;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == STEP_W'(SQRT_STEPS - 1)) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (cmd.load_en) begin
						pend_q <= pend_left;
						cnt_q  <= '0;
						state_q <= (pend_left != '0) ? S_RD : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`GGF_ASSERT(a_pos_in_grid, (col_pos_q < cols) && (row_pos_q < rows))
	`GGF_ASSERT(a_rd_has_work, (state_q != S_RD) || (pend_q != 3'b000))
	`GGF_ASSERT_NEXT(a_load_shows, cmd.load_en, out_valid_q)

endmodule

/* sv/grid_gradient_field.sv */
// Each result of an item passes through these steps in order: 4 line-store
// reads, read wait, difference, scale multiply, square, sum, square root iterations, load.
// An item yields no result or up to 3 results; one with no result leaves the block idle,
// and the load step of a result waits while the output register stays stalled.
// A new item is taken while the last result of the previous one waits in the output register.
// Reset (async, active low) clears position and handshake state; counts return to 1024,
// spacings to 1.0. The line store is not cleared.
module grid_gradient_field #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ggf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ggf_pkg::CFG_DATA_W-1:0] cfg_data,
	ggf_in_if.sink                         pot,
	ggf_out_if.source                      res
);
	import ggf_pkg::*;

	localparam int CMAX = (MAX_COLS > CNT_MAX) ? CNT_MAX : MAX_COLS;
	localparam int RMAX = (MAX_ROWS > CNT_MAX) ? CNT_MAX : MAX_ROWS;
	localparam int CIW  = $clog2(CMAX);

	ggf_cmd_t         cmd;
	logic [CIW-1:0]   wr_col, rd_col;
	logic [IDX_W-1:0] pt_row, pt_col;

	ggf_ctrl #(
		.RMAX(RMAX),
		.CIW (CIW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.col_lim  (CNT_W'(CMAX)),
		.in_valid (pot.valid),
		.in_ready (pot.ready),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.cmd      (cmd),
		.wr_col   (wr_col),
		.rd_col   (rd_col),
		.pt_row   (pt_row),
		.pt_col   (pt_col)
	);

	ggf_datapath #(
		.CMAX(CMAX),
		.CIW (CIW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.wr_col       (wr_col),
		.rd_col       (rd_col),
		.potential    (pot.potential),
		.pt_row       (pt_row),
		.pt_col       (pt_col),
		.out_row      (res.out_row),
		.out_col      (res.out_col),
		.field_row_dir(res.field_row_dir),
		.field_col_dir(res.field_col_dir),
		.magnitude    (res.magnitude),
		.last_of_grid (res.last_of_grid)
	);

endmodule
